>>> rtl/core/mahd_pkg.sv
// Shared types, constants and lookup tables for the audio frame header decoder.
package mahd_pkg;

  // Field widths of the header word and the decoded result.
  localparam int HeaderW  = 32;
  localparam int KbpsW    = 9;
  localparam int RateW    = 16;
  localparam int SamplesW = 11;
  localparam int BytesW   = 12;
  localparam int FlagsW   = 5;

  // Frame length datapath widths.
  // The dividend is (slot factor * kbps) << version shift, below 2^29.
  localparam int KMulW      = 18;
  localparam int DividendW  = 29;
  localparam int RecipShift = DividendW;
  localparam int RecipW     = 15;
  localparam int QuotW      = 15;
  localparam int ProdW      = DividendW + RecipW;
  localparam int QrW        = QuotW + RateW;

  // Version codes as reported on the result.
  localparam logic [1:0] VER_MPEG1  = 2'd1;
  localparam logic [1:0] VER_MPEG2  = 2'd2;
  localparam logic [1:0] VER_MPEG25 = 2'd3;

  // Layer codes as reported on the result.
  localparam logic [1:0] LAYER_RSVD = 2'd0;
  localparam logic [1:0] LAYER_1    = 2'd1;
  localparam logic [1:0] LAYER_2    = 2'd2;
  localparam logic [1:0] LAYER_3    = 2'd3;

  // Samples per frame.
  localparam logic [SamplesW-1:0] SAMPLES_L1   = 11'd384;
  localparam logic [SamplesW-1:0] SAMPLES_FULL = 11'd1152;
  localparam logic [SamplesW-1:0] SAMPLES_HALF = 11'd576;

  // Numerator factors: 12 * 1000 for Layer I, samples * 1000 / 8 otherwise.
  localparam logic [KMulW-1:0] KMUL_L1   = 18'd12000;
  localparam logic [KMulW-1:0] KMUL_FULL = 18'd144000;
  localparam logic [KMulW-1:0] KMUL_HALF = 18'd72000;

  // Base sample rates of MPEG-1; the later versions divide them by 2 or 4.
  localparam int Rate44k1 = 44100;
  localparam int Rate48k  = 48000;
  localparam int Rate32k  = 32000;

  // Floor reciprocals scaled by 2^RecipShift.
  localparam int Recip44k1 = (1 << RecipShift) / Rate44k1;
  localparam int Recip48k  = (1 << RecipShift) / Rate48k;
  localparam int Recip32k  = (1 << RecipShift) / Rate32k;

  // Sample rate index of the header.
  typedef enum logic [1:0] {
    RATE_44K1,
    RATE_48K,
    RATE_32K,
    RATE_RSVD
  } rate_sel_t;

  // Bitrate tables in kbit/s, indexed by the bitrate index.
  localparam logic [KbpsW-1:0] KBPS_V1L1 [16] = '{
    9'd0, 9'd32, 9'd64, 9'd96, 9'd128, 9'd160, 9'd192, 9'd224,
    9'd256, 9'd288, 9'd320, 9'd352, 9'd384, 9'd416, 9'd448, 9'd0};
  localparam logic [KbpsW-1:0] KBPS_V1L2 [16] = '{
    9'd0, 9'd32, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96, 9'd112,
    9'd128, 9'd160, 9'd192, 9'd224, 9'd256, 9'd320, 9'd384, 9'd0};
  localparam logic [KbpsW-1:0] KBPS_V1L3 [16] = '{
    9'd0, 9'd32, 9'd40, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96,
    9'd112, 9'd128, 9'd160, 9'd192, 9'd224, 9'd256, 9'd320, 9'd0};
  localparam logic [KbpsW-1:0] KBPS_V2L1 [16] = '{
    9'd0, 9'd32, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96, 9'd112,
    9'd128, 9'd144, 9'd160, 9'd176, 9'd192, 9'd224, 9'd256, 9'd0};
  localparam logic [KbpsW-1:0] KBPS_V2L23 [16] = '{
    9'd0, 9'd8, 9'd16, 9'd24, 9'd32, 9'd40, 9'd48, 9'd56,
    9'd64, 9'd80, 9'd96, 9'd112, 9'd128, 9'd144, 9'd160, 9'd0};

  // Decoded fields that travel down the pipeline next to the divider.
  typedef struct packed {
    logic                header_valid;
    logic [1:0]          mpeg_version;
    logic [1:0]          layer_number;
    logic                crc_present;
    logic [KbpsW-1:0]    bitrate_kbps;
    logic [RateW-1:0]    sample_rate_hz;
    logic                padding_bit;
    logic [1:0]          channel_mode;
    logic [1:0]          mode_extension;
    logic [FlagsW-1:0]   flag_bits;
    logic [SamplesW-1:0] samples_per_frame;
    logic                is_layer1;
    logic                rate_zero;
  } fields_t;

  // Stage loads of the divider.
  typedef struct packed {
    logic load_est;
    logic load_prod;
  } div_ctrl_t;

  // Bitrate lookup; the caller handles the reserved layer.
  function automatic logic [KbpsW-1:0] kbps_lookup(logic [1:0] ver, logic [1:0] lay,
                                                   logic [3:0] idx);
    logic [KbpsW-1:0] kbps;
    kbps = '0;
    if (ver == VER_MPEG1) begin
      case (lay)
        LAYER_1: kbps = KBPS_V1L1[idx];
        LAYER_2: kbps = KBPS_V1L2[idx];
        LAYER_3: kbps = KBPS_V1L3[idx];
        default: kbps = '0;
      endcase
    end else begin
      case (lay)
        LAYER_1: kbps = KBPS_V2L1[idx];
        LAYER_2: kbps = KBPS_V2L23[idx];
        LAYER_3: kbps = KBPS_V2L23[idx];
        default: kbps = '0;
      endcase
    end
    return kbps;
  endfunction

  // MPEG-1 sample rate for the index; zero for the reserved index.
  function automatic logic [RateW-1:0] base_rate(rate_sel_t sel);
    logic [RateW-1:0] rate;
    case (sel)
      RATE_44K1: rate = RateW'(Rate44k1);
      RATE_48K:  rate = RateW'(Rate48k);
      RATE_32K:  rate = RateW'(Rate32k);
      default:   rate = '0;
    endcase
    return rate;
  endfunction

  // Scaled reciprocal of the base rate.
  function automatic logic [RecipW-1:0] rate_recip(rate_sel_t sel);
    logic [RecipW-1:0] recip;
    case (sel)
      RATE_44K1: recip = RecipW'(Recip44k1);
      RATE_48K:  recip = RecipW'(Recip48k);
      RATE_32K:  recip = RecipW'(Recip32k);
      default:   recip = '0;
    endcase
    return recip;
  endfunction

endpackage

>>> rtl/core/mpeg_audio_header_decode_core.sv
// Throughput: one header per cycle while the output does not stall; the five stages
// are decode and table lookup, numerator multiply, reciprocal multiply, back-multiply,
// and correction into the output. A stall on the output holds the full stages from the
// output back to the first bubble; bubbles are filled while stalled.
// Synchronous active-low reset clears the stage valid bits only.
module mpeg_audio_header_decode_core (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [mahd_pkg::HeaderW-1:0]     in_header_word,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic                             out_header_valid,
  output logic [1:0]                       out_mpeg_version,
  output logic [1:0]                       out_layer_number,
  output logic                             out_crc_present,
  output logic [mahd_pkg::KbpsW-1:0]       out_bitrate_kbps,
  output logic [mahd_pkg::RateW-1:0]       out_sample_rate_hz,
  output logic                             out_padding_bit,
  output logic [1:0]                       out_channel_mode,
  output logic [1:0]                       out_mode_extension,
  output logic [mahd_pkg::FlagsW-1:0]      out_flag_bits,
  output logic [mahd_pkg::SamplesW-1:0]    out_samples_per_frame,
  output logic [mahd_pkg::BytesW-1:0]      out_frame_bytes
);
  import mahd_pkg::*;

  localparam int Stages = 5;

  // Stage valid bits and the ready chain that lets bubbles collapse.
  logic [Stages-1:0] vld_r;
  logic [Stages-1:0] rdy;

  fields_t           fld_r [Stages-1];
  fields_t           out_fld_r;
  logic [BytesW-1:0] out_bytes_r;
  logic [BytesW-1:0] bytes_nxt;

  // Stage 1 decode signals.
  logic [HeaderW-1:0]  w;
  logic [1:0]          ver;
  logic [1:0]          lay;
  logic [KbpsW-1:0]    kbps;
  rate_sel_t           sel;
  logic [1:0]          shift;
  logic                rate_zero;
  logic [RateW-1:0]    rate_hz;
  logic [SamplesW-1:0] samples;
  logic [KMulW-1:0]    kmul;
  fields_t             s1_fld_nxt;

  logic [KMulW-1:0]    s1_kmul_r;
  logic [KbpsW-1:0]    s1_kbps_r;
  logic [1:0]          s1_shift_r;
  rate_sel_t           s1_sel_r;

  // Stage 2 numerator.
  logic [KMulW+KbpsW-1:0] s2_prod;
  logic [DividendW-1:0]   s2_dividend_nxt;
  logic [DividendW-1:0]   s2_dividend_r;
  rate_sel_t              s2_sel_r;

  div_ctrl_t           div_ctrl;
  logic [QuotW-1:0]    quotient;
  logic [QuotW:0]      slot_sum;

  // A stage may load when it is empty or its successor is loading.
  always_comb begin
    rdy[Stages-1] = !vld_r[Stages-1] || !out_stall;
    for (int i = Stages - 2; i >= 0; i--) begin
      rdy[i] = !vld_r[i] || rdy[i+1];
    end
  end

  assign in_stall = !rdy[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (rdy[0]) begin
        vld_r[0] <= in_valid;
      end
      for (int i = 1; i < Stages; i++) begin
        if (rdy[i]) begin
          vld_r[i] <= vld_r[i-1];
        end
      end
    end
  end

  // Stage 1: split the header word and look up bitrate and sample rate.
  always_comb begin
    w   = in_header_word;
    ver = w[20] ? (w[19] ? VER_MPEG1 : VER_MPEG2) : VER_MPEG25;
    case (w[18:17])
      2'b11:   lay = LAYER_1;
      2'b10:   lay = LAYER_2;
      2'b01:   lay = LAYER_3;
      default: lay = LAYER_RSVD;
    endcase
    kbps      = (lay == LAYER_RSVD) ? '0 : kbps_lookup(ver, lay, w[15:12]);
    sel       = rate_sel_t'(w[11:10]);
    shift     = ver - 2'd1;
    rate_zero = (lay == LAYER_RSVD) || (sel == RATE_RSVD);
    rate_hz   = rate_zero ? '0 : (base_rate(sel) >> shift);

    if (lay == LAYER_1) begin
      samples = SAMPLES_L1;
      kmul    = KMUL_L1;
    end else if (lay == LAYER_2 || ver == VER_MPEG1) begin
      samples = SAMPLES_FULL;
      kmul    = KMUL_FULL;
    end else begin
      samples = SAMPLES_HALF;
      kmul    = KMUL_HALF;
    end

    // The eleven sync bits are the top bits of the word.
    s1_fld_nxt.header_valid      = (&w[31:21]) && (lay != LAYER_RSVD) &&
                                   (kbps != '0) && !rate_zero;
    s1_fld_nxt.mpeg_version      = ver;
    s1_fld_nxt.layer_number      = lay;
    s1_fld_nxt.crc_present       = !w[16];
    s1_fld_nxt.bitrate_kbps      = kbps;
    s1_fld_nxt.sample_rate_hz    = rate_hz;
    s1_fld_nxt.padding_bit       = w[9];
    s1_fld_nxt.channel_mode      = w[7:6];
    s1_fld_nxt.mode_extension    = w[5:4];
    s1_fld_nxt.flag_bits         = {w[8], w[3:0]};
    s1_fld_nxt.samples_per_frame = samples;
    s1_fld_nxt.is_layer1         = (lay == LAYER_1);
    s1_fld_nxt.rate_zero         = rate_zero;
  end

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      fld_r[0]   <= s1_fld_nxt;
      s1_kmul_r  <= kmul;
      s1_kbps_r  <= kbps;
      s1_shift_r <= shift;
      s1_sel_r   <= sel;
    end
  end

  // Stage 2: numerator, scaled up for the halved and quartered sample rates.
  assign s2_prod         = s1_kmul_r * s1_kbps_r;
  assign s2_dividend_nxt = DividendW'(s2_prod) << s1_shift_r;

  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      fld_r[1]      <= fld_r[0];
      s2_dividend_r <= s2_dividend_nxt;
      s2_sel_r      <= s1_sel_r;
    end
  end

  // Stages 3 and 4 live in the divider; the side fields move in step.
  assign div_ctrl.load_est  = rdy[2];
  assign div_ctrl.load_prod = rdy[3];

  mahd_recip_div u_div (
    .clk      (clk),
    .ctrl     (div_ctrl),
    .dividend (s2_dividend_r),
    .sel      (s2_sel_r),
    .quotient (quotient)
  );

  always_ff @(posedge clk) begin
    if (rdy[2]) begin
      fld_r[2] <= fld_r[1];
    end
    if (rdy[3]) begin
      fld_r[3] <= fld_r[2];
    end
  end

  // Stage 5: add the padding slot; Layer I slots are four bytes.
  assign slot_sum = {1'b0, quotient} + (QuotW + 1)'(fld_r[3].padding_bit);

  always_comb begin
    if (fld_r[3].rate_zero) begin
      bytes_nxt = '0;
    end else if (fld_r[3].is_layer1) begin
      bytes_nxt = BytesW'({slot_sum, 2'b00});
    end else begin
      bytes_nxt = BytesW'(slot_sum);
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[4]) begin
      out_fld_r   <= fld_r[3];
      out_bytes_r <= bytes_nxt;
    end
  end

  // Result ports.
  assign out_valid             = vld_r[Stages-1];
  assign out_header_valid      = out_fld_r.header_valid;
  assign out_mpeg_version      = out_fld_r.mpeg_version;
  assign out_layer_number      = out_fld_r.layer_number;
  assign out_crc_present       = out_fld_r.crc_present;
  assign out_bitrate_kbps      = out_fld_r.bitrate_kbps;
  assign out_sample_rate_hz    = out_fld_r.sample_rate_hz;
  assign out_padding_bit       = out_fld_r.padding_bit;
  assign out_channel_mode      = out_fld_r.channel_mode;
  assign out_mode_extension    = out_fld_r.mode_extension;
  assign out_flag_bits         = out_fld_r.flag_bits;
  assign out_samples_per_frame = out_fld_r.samples_per_frame;
  assign out_frame_bytes       = out_bytes_r;

endmodule

>>> rtl/core/mahd_recip_div.sv
// Divides the frame length numerator by one of the three base sample rates.
// A reciprocal multiply gives an estimate that is exact or one low; a second
// multiply forms the remainder, and a compare adds the missing one.
module mahd_recip_div (
  input  logic                      clk,
  input  mahd_pkg::div_ctrl_t       ctrl,
  input  logic [mahd_pkg::DividendW-1:0] dividend,
  input  mahd_pkg::rate_sel_t       sel,
  output logic [mahd_pkg::QuotW-1:0] quotient
);
  import mahd_pkg::*;

  logic [ProdW-1:0]     recip_prod;
  logic [QuotW-1:0]     est_q_nxt;
  logic [QuotW-1:0]     est_q_r;
  logic [DividendW-1:0] est_dividend_r;
  rate_sel_t            est_sel_r;

  logic [QrW-1:0]       prod_qr_nxt;
  logic [QrW-1:0]       prod_qr_r;
  logic [QuotW-1:0]     prod_q_r;
  logic [DividendW-1:0] prod_dividend_r;
  rate_sel_t            prod_sel_r;

  logic [DividendW-1:0] remainder;

  // Estimate stage: multiply by the scaled reciprocal and keep the high bits.
  assign recip_prod = dividend * rate_recip(sel);
  assign est_q_nxt  = recip_prod[ProdW-1:RecipShift];

  always_ff @(posedge clk) begin
    if (ctrl.load_est) begin
      est_q_r        <= est_q_nxt;
      est_dividend_r <= dividend;
      est_sel_r      <= sel;
    end
  end

  // Back-multiply stage: estimate times divisor.
  assign prod_qr_nxt = est_q_r * base_rate(est_sel_r);

  always_ff @(posedge clk) begin
    if (ctrl.load_prod) begin
      prod_qr_r       <= prod_qr_nxt;
      prod_q_r        <= est_q_r;
      prod_dividend_r <= est_dividend_r;
      prod_sel_r      <= est_sel_r;
    end
  end

  // Correction: the remainder is below twice the divisor, so one step fixes it.
  assign remainder = prod_dividend_r - DividendW'(prod_qr_r);
  assign quotient  = (remainder >= DividendW'(base_rate(prod_sel_r))) ?
                     prod_q_r + QuotW'(1) : prod_q_r;

endmodule
